// ===== rtl/core/fpba_pkg.sv =====
// ----------------------------------------------------------------------------
// fpba_pkg: shared types and constants of the fit-policy block allocator
// Holds the policy, item kind and register codes, the controller states and
// the control word that the top level broadcasts to every table cell.
// ----------------------------------------------------------------------------
package fpba_pkg;

    // Default table geometry
    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Fixed field widths of the ports
    localparam int IN_SIZE_W = 16;
    localparam int FREE_W    = 20;
    localparam int FREE_MAX  = 20'hFFFFF;
    localparam int BIDX_W    = 4;
    localparam int CFG_W     = 5;

    // Register indexes of the configuration port
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_BLOCKS = 1'b1;

    localparam logic [1:0] POLICY_RST = 2'd0;
    localparam logic [4:0] BLOCKS_RST = 5'd16;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } policy_t;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_REQUEST = 2'd1,
        KIND_RESTORE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Table update strobes broadcast to all cells
    typedef struct packed {
        logic load;
        logic restore;
        logic sub;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/fpba_cell.sv =====
// ----------------------------------------------------------------------------
// fpba_cell: one table entry of the allocator chain
// Stores one block's original and remaining size, applies load, restore and
// grant updates, and folds its entry into the scan word passing through it.
// ----------------------------------------------------------------------------
module fpba_cell
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF,
    parameter int INDEX      = 0,
    localparam int IDX_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1),
    localparam int ACC_W     = SIZE_BITS + $clog2(NUM_BLOCKS + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  policy_t              policy,
    input  logic [CNT_W-1:0]     active_cnt,
    input  logic [IN_SIZE_W-1:0] need,
    input  cell_ctrl_t           ctrl,
    input  logic [IDX_W-1:0]     sel,
    input  logic [SIZE_BITS-1:0] wdata,
    input  logic                 found_in,
    input  logic [IDX_W-1:0]     idx_in,
    input  logic [SIZE_BITS-1:0] best_in,
    input  logic [ACC_W-1:0]     acc_in,
    output logic                 found_out,
    output logic [IDX_W-1:0]     idx_out,
    output logic [SIZE_BITS-1:0] best_out,
    output logic [ACC_W-1:0]     acc_out
);

    localparam int WIDE_W = (SIZE_BITS > IN_SIZE_W) ? SIZE_BITS : IN_SIZE_W;

    logic [SIZE_BITS-1:0] orig_reg, orig_next;
    logic [SIZE_BITS-1:0] rem_reg, rem_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [SIZE_BITS-1:0] best_reg, best_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;

    logic active;
    logic fits;
    logic better;
    logic take;
    logic hit;

    // Decide whether this entry replaces the candidate in the scan word
    always_comb
    begin
        active = CNT_W'(INDEX) < active_cnt;
        fits   = WIDE_W'(rem_reg) >= WIDE_W'(need);
        unique case (policy)
            POL_FIRST: better = !found_in;
            POL_BEST:  better = !found_in || (rem_reg < best_in);
            POL_WORST: better = !found_in || (rem_reg > best_in);
            default:   better = 1'b0;
        endcase
        take       = active && fits && better;
        found_next = found_in || take;
        idx_next   = take ? IDX_W'(INDEX) : idx_in;
        best_next  = take ? rem_reg : best_in;
        acc_next   = acc_in + (active ? ACC_W'(rem_reg) : ACC_W'(0));
    end

    // Apply table updates: load, restore, or take a grant out of this block
    always_comb
    begin
        hit       = sel == IDX_W'(INDEX);
        orig_next = orig_reg;
        rem_next  = rem_reg;
        priority if (ctrl.load && hit)
        begin
            orig_next = wdata;
            rem_next  = wdata;
        end
        else if (ctrl.restore)
        begin
            rem_next = orig_reg;
        end
        else if (ctrl.sub && hit)
        begin
            rem_next = rem_reg - SIZE_BITS'(need);
        end
    end

    // Hold the table entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orig_reg <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            orig_reg <= orig_next;
            rem_reg  <= rem_next;
        end
    end

    // Advance the scan word to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        best_reg <= best_next;
        acc_reg  <= acc_next;
    end

    assign found_out = found_reg;
    assign idx_out   = idx_reg;
    assign best_out  = best_reg;
    assign acc_out   = acc_reg;

endmodule

// ===== rtl/core/fit_policy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// fit_policy_block_allocator: first, best and worst fit block allocator
// Keeps a table of blocks in a chain of cells and serves load, request and
// restore words, reporting the grant, the block and the total free space.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (kind, block_slot, size) are taken at a rising edge with
//   start high and busy low. Each word gives one result word on granted,
//   block_index and free_total, shown for one cycle with done high; the
//   receiver cannot stall, so the result must be taken in that cycle.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 policy, 1 blocks in use). The user must write only while busy is
//   low; the block itself does not enforce this. Throughput: one word at
//   a time; busy stays high until the result word is registered. The
//   scan word travels through the cell chain one cell per cycle,
//   collecting the fitting block and the free sum, and the finish state
//   then commits the grant and registers the result. A new word may be
//   started in the cycle done is high.
//   Reset clears the table to zero, selects first fit and puts 16 blocks in
//   use; busy and done are low after reset.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           kind,
    input  logic [3:0]           block_slot,
    input  logic [IN_SIZE_W-1:0] size,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output logic                 granted,
    output logic [BIDX_W-1:0]    block_index,
    output logic [FREE_W-1:0]    free_total
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int ACC_W = SIZE_BITS + $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W = (ACC_W > FREE_W) ? ACC_W + 1 : FREE_W + 1;
    localparam int SCAN_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // Configuration registers
    logic [1:0]       policy_reg;
    logic [CFG_W-1:0] blocks_reg;

    // Controller
    state_t               state_reg, state_next;
    logic [SCAN_W-1:0]    cnt_reg, cnt_next;
    kind_t                kind_reg, kind_next;
    logic [IN_SIZE_W-1:0] need_reg, need_next;
    logic [3:0]           block_slot_reg, block_slot_next;

    // Result word
    logic              done_reg, done_next;
    logic              granted_reg, granted_next;
    logic [BIDX_W-1:0] index_reg, index_next;
    logic [FREE_W-1:0] free_reg, free_next;

    logic             accept;
    logic             load_hit;
    logic             grant_c;
    logic [CMP_W-1:0] acc_fin;
    logic [CNT_W-1:0] active_cnt;
    cell_ctrl_t       ctrl;
    logic [IDX_W-1:0] sel;

    // Scan chain links
    logic                 found_w [NUM_BLOCKS+1];
    logic [IDX_W-1:0]     idx_w   [NUM_BLOCKS+1];
    logic [SIZE_BITS-1:0] best_w  [NUM_BLOCKS+1];
    logic [ACC_W-1:0]     acc_w   [NUM_BLOCKS+1];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_RST;
            blocks_reg <= BLOCKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POLICY: policy_reg <= cfg_data[1:0];
                REG_BLOCKS: blocks_reg <= cfg_data;
                default:    blocks_reg <= blocks_reg;
            endcase
        end
    end

    // Clamp blocks in use to the table size
    always_comb
    begin
        if (int'(blocks_reg) > NUM_BLOCKS)
        begin
            active_cnt = CNT_W'(NUM_BLOCKS);
        end
        else
        begin
            active_cnt = CNT_W'(blocks_reg);
        end
    end

    assign accept   = start && (state_reg == ST_IDLE);
    assign load_hit = int'(block_slot) < NUM_BLOCKS;
    assign grant_c  = (kind_reg == KIND_REQUEST) && found_w[NUM_BLOCKS];

    // Next state, table strobes and result word
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        kind_next    = kind_reg;
        need_next    = need_reg;
        done_next    = 1'b0;
        granted_next = granted_reg;
        index_next   = index_reg;
        free_next    = free_reg;
        ctrl         = '0;
        sel          = IDX_W'(block_slot);
        acc_fin      = CMP_W'(acc_w[NUM_BLOCKS])
                       - (grant_c ? CMP_W'(need_reg) : CMP_W'(0));
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next    = kind_t'(kind);
                    need_next    = size;
                    cnt_next     = '0;
                    state_next   = ST_SCAN;
                    ctrl.load    = (kind_t'(kind) == KIND_LOAD) && load_hit;
                    ctrl.restore = kind_t'(kind) == KIND_RESTORE;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + SCAN_W'(1);
                if (int'(cnt_reg) == NUM_BLOCKS - 1)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                sel          = idx_w[NUM_BLOCKS];
                ctrl.sub     = grant_c;
                done_next    = 1'b1;
                granted_next = grant_c;
                if (kind_reg == KIND_LOAD)
                begin
                    index_next = BIDX_W'(block_slot_reg);
                end
                else if (grant_c)
                begin
                    index_next = BIDX_W'(idx_w[NUM_BLOCKS]);
                end
                else
                begin
                    index_next = '0;
                end
                if (acc_fin > CMP_W'(FREE_MAX))
                begin
                    free_next = FREE_W'(FREE_MAX);
                end
                else
                begin
                    free_next = FREE_W'(acc_fin);
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the load slot for the echo in the result word
    assign block_slot_next = accept ? block_slot : block_slot_reg;

    always_ff @(posedge clk)
    begin
        block_slot_reg <= block_slot_next;
        kind_reg       <= kind_next;
        need_reg       <= need_next;
        cnt_reg        <= cnt_next;
        granted_reg    <= granted_next;
        index_reg      <= index_next;
        free_reg       <= free_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Launch an empty scan word into the head of the chain
    assign found_w[0] = 1'b0;
    assign idx_w[0]   = '0;
    assign best_w[0]  = '0;
    assign acc_w[0]   = '0;

    // Chain of table cells
    for (genvar i = 0; i < NUM_BLOCKS; i++)
    begin : g_cell
        fpba_cell #(
            .NUM_BLOCKS (NUM_BLOCKS),
            .SIZE_BITS  (SIZE_BITS),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .policy     (policy_t'(policy_reg)),
            .active_cnt (active_cnt),
            .need       (need_reg),
            .ctrl       (ctrl),
            .sel        (sel),
            .wdata      (SIZE_BITS'(size)),
            .found_in   (found_w[i]),
            .idx_in     (idx_w[i]),
            .best_in    (best_w[i]),
            .acc_in     (acc_w[i]),
            .found_out  (found_w[i+1]),
            .idx_out    (idx_w[i+1]),
            .best_out   (best_w[i+1]),
            .acc_out    (acc_w[i+1])
        );
    end

    assign busy        = state_reg != ST_IDLE;
    assign done        = done_reg;
    assign granted     = granted_reg;
    assign block_index = index_reg;
    assign free_total  = free_reg;

    // A result word only follows the commit cycle
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_FINISH))
        else $error("result word without a commit cycle");

    // Every finished item presents its result word
    a_done_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done_reg)
        else $error("controller released without a result word");

    // An accepted word keeps the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start a scan");

endmodule
